[sv/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants of the ball Euclidean distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

	localparam int VALUE_W  = 32;
	localparam int MAG_W    = 32;
	localparam int SUM_W    = 64;
	localparam int RADIUS_W = 48;

	// Jobs waiting between the accumulator and the root unit.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One finished vector pair, handed from the front part to the back part.
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic                saturated;
		logic                equal;
		logic [RADIUS_W-1:0] first_radius;
		logic [RADIUS_W-1:0] second_radius;
	} job_t;

	// Fill status of the job queue.
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

`default_nettype wire

[sv/ball_euclidean_distance.sv]
// ----------------------------------------------------------------------------
// ball_euclidean_distance
// Euclidean distance of two vectors, with covering-radius tests on the balls.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    carries
//   pair      pair_valid / pair_stall      one element pair per beat, radii
//   result    result_valid / result_stall  distance, gap and ball tests
//
// The front part takes one pair beat per cycle while pair_stall is low:
// difference, a registered 32x32 square, then a saturating 64-bit
// accumulation. A pair beat marked last hands the finished sum to a
// two-entry job queue. The back part computes the 32+FRACTION_BITS-bit
// root one bit per cycle, then does the radius arithmetic in ST_SUM and
// ST_DONE; it takes the next vector pair only once it is back in ST_IDLE.
// Reset is asynchronous and clears only the control state and the accumulator;
// there is no clearing pass. pair_stall rises only when a last beat finds
// the job queue full; result_stall holds the result register and the root
// unit waits on it at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module ball_euclidean_distance #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               pair_valid,
	output logic                                    pair_stall,
	input  wire logic signed [bed_pkg::VALUE_W-1:0] first_value,
	input  wire logic signed [bed_pkg::VALUE_W-1:0] second_value,
	input  wire logic                               first_present,
	input  wire logic                               second_present,
	input  wire logic                               last_pair,
	input  wire logic [bed_pkg::RADIUS_W-1:0]       first_radius,
	input  wire logic [bed_pkg::RADIUS_W-1:0]       second_radius,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic [bed_pkg::RADIUS_W-1:0]            ball_distance,
	output logic [bed_pkg::RADIUS_W-1:0]            outer_gap,
	output logic                                    balls_overlap,
	output logic                                    first_contains_second,
	output logic                                    second_contains_first,
	output logic                                    vectors_equal,
	output logic                                    sum_saturated
);

	// Jobs cross from the accumulator to the root unit through the queue, so
	// the next vector pair streams in while the previous root is worked out.
	logic                   push, pop;
	bed_pkg::job_t          push_job, pop_job;
	bed_pkg::queue_status_t q_status;

	bed_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.pair_valid     (pair_valid),
		.pair_stall     (pair_stall),
		.first_value    (first_value),
		.second_value   (second_value),
		.first_present  (first_present),
		.second_present (second_present),
		.last_pair      (last_pair),
		.first_radius   (first_radius),
		.second_radius  (second_radius),
		.push           (push),
		.push_job       (push_job),
		.q_status       (q_status)
	);

	bed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	// The back part owns the result register, which parts the root unit
	// from a stalled consumer.
	bed_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.q_status              (q_status),
		.pop_job               (pop_job),
		.pop                   (pop),
		.result_valid          (result_valid),
		.result_stall          (result_stall),
		.ball_distance         (ball_distance),
		.outer_gap             (outer_gap),
		.balls_overlap         (balls_overlap),
		.first_contains_second (first_contains_second),
		.second_contains_first (second_contains_first),
		.vectors_equal         (vectors_equal),
		.sum_saturated         (sum_saturated)
	);

endmodule

`default_nettype wire

[sv/bed_front.sv]
// ----------------------------------------------------------------------------
// bed_front
// Takes element pairs, squares their difference and accumulates the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pair_valid,
	output logic                                  pair_stall,
	input  wire logic signed [bed_pkg::VALUE_W-1:0] first_value,
	input  wire logic signed [bed_pkg::VALUE_W-1:0] second_value,
	input  wire logic                             first_present,
	input  wire logic                             second_present,
	input  wire logic                             last_pair,
	input  wire logic [bed_pkg::RADIUS_W-1:0]     first_radius,
	input  wire logic [bed_pkg::RADIUS_W-1:0]     second_radius,
	output logic                                  push,
	output bed_pkg::job_t                         push_job,
	input  wire bed_pkg::queue_status_t           q_status
);

	logic signed [bed_pkg::VALUE_W:0] a_ext, b_ext, diff;
	logic [bed_pkg::MAG_W-1:0]        mag;
	logic                             pair_eq;
	logic                             advance;
	logic [bed_pkg::SUM_W:0]          add_full;
	logic [bed_pkg::SUM_W-1:0]        sum_next;
	logic                             sat_next, eq_next;

	logic                          valid_s1, eq_s1, last_s1;
	logic [bed_pkg::MAG_W-1:0]     mag_s1;
	logic [bed_pkg::RADIUS_W-1:0]  r1_s1, r2_s1;
	logic                          valid_s2, eq_s2, last_s2;
	logic [2*bed_pkg::MAG_W-1:0]   sq_s2;
	logic [bed_pkg::RADIUS_W-1:0]  r1_s2, r2_s2;

	logic [bed_pkg::SUM_W-1:0] sum_q;
	logic                      ovf_q, eq_q;

	// An absent element counts as zero.
	always_comb begin
		a_ext   = first_present  ? {first_value[bed_pkg::VALUE_W-1], first_value}   : '0;
		b_ext   = second_present ? {second_value[bed_pkg::VALUE_W-1], second_value} : '0;
		diff    = a_ext - b_ext;
		mag     = diff[bed_pkg::VALUE_W] ? bed_pkg::MAG_W'(-diff)
		                                 : bed_pkg::MAG_W'(diff);
		pair_eq = (first_present == second_present) && (!first_present || a_ext == b_ext);
	end

	// The whole pipeline holds only when a finished sum finds the queue full.
	assign advance    = !(valid_s2 && last_s2 && q_status.full);
	assign pair_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pair_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1  <= mag;
			eq_s1   <= pair_eq;
			last_s1 <= last_pair;
			r1_s1   <= first_radius;
			r2_s1   <= second_radius;
			sq_s2   <= mag_s1 * mag_s1;
			eq_s2   <= eq_s1;
			last_s2 <= last_s1;
			r1_s2   <= r1_s1;
			r2_s2   <= r2_s1;
		end
	end

	always_comb begin
		add_full = {1'b0, sum_q} + {1'b0, sq_s2};
		sum_next = add_full[bed_pkg::SUM_W] ? '1 : add_full[bed_pkg::SUM_W-1:0];
		sat_next = ovf_q || add_full[bed_pkg::SUM_W];
		eq_next  = eq_q && eq_s2;
	end

	assign push                   = valid_s2 && last_s2 && advance;
	assign push_job.sum           = sum_next;
	assign push_job.saturated     = sat_next;
	assign push_job.equal         = eq_next;
	assign push_job.first_radius  = r1_s2;
	assign push_job.second_radius = r2_s2;

	// The accumulator starts afresh after every last pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
			eq_q  <= 1'b1;
		end else if (valid_s2 && advance) begin
			if (last_s2) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
				eq_q  <= 1'b1;
			end else begin
				sum_q <= sum_next;
				ovf_q <= sat_next;
				eq_q  <= eq_next;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job pushed into a full queue");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (sum_q == '0 && !ovf_q && eq_q))
		else $error("accumulator not cleared after a last pair");

	a_sat_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (sum_q == '1))
		else $error("saturated sum is not at its maximum");

endmodule

`default_nettype wire

[sv/bed_queue.sv]
// ----------------------------------------------------------------------------
// bed_queue
// Short first-in first-out queue of finished sums waiting for the root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bed_pkg::job_t     push_job,
	input  wire logic              pop,
	output bed_pkg::job_t          pop_job,
	output bed_pkg::queue_status_t status
);

	bed_pkg::job_t                entry_q [bed_pkg::QUEUE_DEPTH];
	logic [bed_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bed_pkg::QCNT_W-1:0]   count_q;

	assign status.full      = (count_q == bed_pkg::QCNT_W'(bed_pkg::QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign pop_job          = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bed_pkg::QPTR_W'(bed_pkg::QUEUE_DEPTH - 1))
				            ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bed_pkg::QPTR_W'(bed_pkg::QUEUE_DEPTH - 1))
				            ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/bed_back.sv]
// ----------------------------------------------------------------------------
// bed_back
// Bit-serial square root of a finished sum, radius tests and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_back #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bed_pkg::queue_status_t       q_status,
	input  wire bed_pkg::job_t                pop_job,
	output logic                              pop,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [bed_pkg::RADIUS_W-1:0]      ball_distance,
	output logic [bed_pkg::RADIUS_W-1:0]      outer_gap,
	output logic                              balls_overlap,
	output logic                              first_contains_second,
	output logic                              second_contains_first,
	output logic                              vectors_equal,
	output logic                              sum_saturated
);

	localparam int ROOT_W = bed_pkg::SUM_W / 2 + FRACTION_BITS;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam int WIDE_W = bed_pkg::RADIUS_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [RAD_W-1:0]            rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [ROOT_W-1:0]           root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [bed_pkg::RADIUS_W-1:0] r1_q, r2_q;
	logic                        eq_q, sat_q;
	logic [WIDE_W-1:0]           rs_q, d1_q, d2_q;

	logic [REM_W+1:0]            rem_sh, trial, rem_sub;
	logic                        take;
	logic [bed_pkg::RADIUS_W-1:0] dist48;
	logic [WIDE_W-1:0]           dist_w, gap_w;
	logic                        out_free;

	// One result bit per step: bring down two radicand bits and try root*4+1.
	always_comb begin
		rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial   = (REM_W + 2)'({root_q, 2'b01});
		rem_sub = rem_sh - trial;
		take    = (rem_sh >= trial);
		dist48  = bed_pkg::RADIUS_W'(root_q);
		dist_w  = {1'b0, dist48};
		gap_w   = dist_w - rs_q;
	end

	assign out_free = !result_valid || !result_stall;
	assign pop      = (state_q == ST_IDLE) && q_status.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					rad_q  <= RAD_W'(pop_job.sum) << (2 * FRACTION_BITS);
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(ROOT_W - 1);
					r1_q   <= pop_job.first_radius;
					r2_q   <= pop_job.second_radius;
					eq_q   <= pop_job.equal;
					sat_q  <= pop_job.saturated;
				end
			end
			ST_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= take ? REM_W'(rem_sub) : REM_W'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], take};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_SUM: begin
				rs_q <= {1'b0, r1_q} + {1'b0, r2_q};
				d1_q <= dist_w + {1'b0, r1_q};
				d2_q <= dist_w + {1'b0, r2_q};
			end
			ST_DONE: begin
				if (out_free) begin
					ball_distance         <= dist48;
					outer_gap             <= (dist_w > rs_q) ? gap_w[bed_pkg::RADIUS_W-1:0] : '0;
					balls_overlap         <= (dist_w < rs_q);
					first_contains_second <= (d2_q < {1'b0, r1_q});
					second_contains_first <= (d1_q < {1'b0, r2_q});
					vectors_equal         <= eq_q;
					sum_saturated         <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the final step");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((ball_distance >> ROOT_W) == '0))
		else $error("distance wider than the root");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (outer_gap <= ball_distance))
		else $error("outer gap exceeds distance");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_ROOT && cnt_q == CNT_W'(ROOT_W - 1)))
		else $error("root unit not started after a pop");

endmodule

`default_nettype wire

[dv/tb_ball_euclidean_distance.sv]
// ----------------------------------------------------------------------------
// tb_ball_euclidean_distance
// Self-checking bench for the ball Euclidean distance block.
// ----------------------------------------------------------------------------
// Element pairs are queued up front: a short directed set, then random vector
// pairs, most of them well formed and some with broken presence patterns. A
// clocked driver feeds them to the pair channel. A predictor runs on every
// accepted pair beat and queues the result of each finished vector pair. A
// clocked monitor checks every accepted result beat against the oldest
// queued result, field by field. Both sides pause at random, apart from a
// calm stretch in the middle of the run.
// ----------------------------------------------------------------------------

module tb_ball_euclidean_distance;

	localparam int FRACTION_BITS = 16;
	// Rough time the root unit needs per vector pair, used for the final wait.
	localparam int ROOT_CYCLES   = 35 + FRACTION_BITS;
	localparam int QUIET_LIMIT   = 2000;
	localparam int TARGET_BEATS  = 1850;
	localparam int PAUSE_PERCENT = 17;
	localparam int CALM_FROM     = 700;
	localparam int CALM_TO       = 1000;

	localparam logic signed [bed_pkg::VALUE_W-1:0] VALUE_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [bed_pkg::VALUE_W-1:0] VALUE_MIN  = 32'sh8000_0000;
	localparam logic [bed_pkg::RADIUS_W-1:0]       RADIUS_MAX = '1;

	// How widely the element values of one random vector pair are spread.
	typedef enum int {
		SPAN_EXTREME,
		SPAN_NARROW,
		SPAN_MID,
		SPAN_FULL
	} value_span_t;

	// One pair beat as queued for the driver. A beat with hold_for_drain set
	// is not offered until every outstanding result has been delivered.
	typedef struct {
		logic signed [bed_pkg::VALUE_W-1:0] first_value;
		logic signed [bed_pkg::VALUE_W-1:0] second_value;
		logic                               first_present;
		logic                               second_present;
		logic                               last_pair;
		logic [bed_pkg::RADIUS_W-1:0]       first_radius;
		logic [bed_pkg::RADIUS_W-1:0]       second_radius;
		bit                                 hold_for_drain;
	} pair_beat_t;

	typedef struct {
		logic [bed_pkg::RADIUS_W-1:0] ball_distance;
		logic [bed_pkg::RADIUS_W-1:0] outer_gap;
		logic                         balls_overlap;
		logic                         first_contains_second;
		logic                         second_contains_first;
		logic                         vectors_equal;
		logic                         sum_saturated;
	} ball_result_t;

	logic                               clk;
	logic                               arst_n         = 1'b0;
	logic                               pair_valid     = 1'b0;
	logic                               pair_stall;
	logic signed [bed_pkg::VALUE_W-1:0] first_value    = '0;
	logic signed [bed_pkg::VALUE_W-1:0] second_value   = '0;
	logic                               first_present  = 1'b0;
	logic                               second_present = 1'b0;
	logic                               last_pair      = 1'b0;
	logic [bed_pkg::RADIUS_W-1:0]       first_radius   = '0;
	logic [bed_pkg::RADIUS_W-1:0]       second_radius  = '0;
	logic                               result_valid;
	logic                               result_stall   = 1'b0;
	logic [bed_pkg::RADIUS_W-1:0]       ball_distance;
	logic [bed_pkg::RADIUS_W-1:0]       outer_gap;
	logic                               balls_overlap;
	logic                               first_contains_second;
	logic                               second_contains_first;
	logic                               vectors_equal;
	logic                               sum_saturated;

	pair_beat_t   pending_beats[$];
	ball_result_t awaited_results[$];
	pair_beat_t   beat_on_wire;

	// Running state of the predictor for the vector pair in progress.
	logic [bed_pkg::SUM_W-1:0] run_sum     = '0;
	bit                        run_clamped = 1'b0;
	bit                        run_equal   = 1'b1;

	int unsigned beats_taken    = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;

	ball_euclidean_distance #(
		.FRACTION_BITS(FRACTION_BITS)
	) DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Bit-serial floor root of s scaled by 2^(2*FRACTION_BITS). The scaled
	// operand is at most 96 bits wide, so 128-bit trial squares never wrap.
	function automatic logic [bed_pkg::RADIUS_W-1:0] fixed_point_root(
			input logic [bed_pkg::SUM_W-1:0] s);
		logic [127:0]                 target;
		logic [127:0]                 trial;
		logic [bed_pkg::RADIUS_W-1:0] root;
		target = {64'd0, s} << (2 * FRACTION_BITS);
		root   = '0;
		for (int b = bed_pkg::RADIUS_W - 1; b >= 0; b--) begin
			trial = {80'd0, root} | (128'd1 << b);
			if (trial * trial <= target)
				root = trial[bed_pkg::RADIUS_W-1:0];
		end
		return root;
	endfunction

	// Folds one accepted pair beat into the running sum and the equality
	// flag. On the last beat the result is queued and the state goes back to
	// its reset value, ready for the next vector pair.
	task automatic accumulate_pair(input pair_beat_t beat);
		logic signed [63:0]           elem_a;
		logic signed [63:0]           elem_b;
		logic signed [63:0]           delta;
		logic [63:0]                  mag;
		logic [63:0]                  square;
		logic [64:0]                  total;
		logic [bed_pkg::RADIUS_W-1:0] root_val;
		logic [bed_pkg::RADIUS_W:0]   dist_wide;
		logic [bed_pkg::RADIUS_W:0]   radii;
		ball_result_t                 res;
		// An absent element counts as zero whatever its value field holds.
		elem_a = beat.first_present ?
			{{32{beat.first_value[bed_pkg::VALUE_W-1]}}, beat.first_value} : 64'sd0;
		elem_b = beat.second_present ?
			{{32{beat.second_value[bed_pkg::VALUE_W-1]}}, beat.second_value} : 64'sd0;
		delta  = elem_a - elem_b;
		mag    = delta[63] ? -delta : delta;
		// The magnitude is below 2^32, so its square fits in 64 bits.
		square = mag * mag;
		total  = {1'b0, run_sum} + {1'b0, square};
		if (total[64]) begin
			run_sum     = '1;
			run_clamped = 1'b1;
		end else begin
			run_sum = total[63:0];
		end
		// A pair with neither element present leaves equality alone; a pair
		// with one side missing means the lengths differ.
		if (beat.first_present != beat.second_present ||
				(beat.first_present && elem_a != elem_b))
			run_equal = 1'b0;
		if (beat.last_pair) begin
			root_val  = fixed_point_root(run_sum);
			dist_wide = {1'b0, root_val};
			radii     = {1'b0, beat.first_radius} + {1'b0, beat.second_radius};
			res.ball_distance         = root_val;
			res.outer_gap             = (dist_wide > radii) ?
				bed_pkg::RADIUS_W'(dist_wide - radii) : '0;
			res.balls_overlap         = dist_wide < radii;
			res.first_contains_second =
				dist_wide + beat.second_radius < {1'b0, beat.first_radius};
			res.second_contains_first =
				dist_wide + beat.first_radius < {1'b0, beat.second_radius};
			res.vectors_equal         = run_equal;
			res.sum_saturated         = run_clamped;
			awaited_results.push_back(res);
			run_sum     = '0;
			run_clamped = 1'b0;
			run_equal   = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic signed [bed_pkg::VALUE_W-1:0] pick_value(
			input value_span_t span);
		case (span)
			SPAN_EXTREME: begin
				case ($urandom_range(4))
					0: return VALUE_MAX;
					1: return VALUE_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			SPAN_NARROW: return $signed($urandom_range(256)) - 32'sd128;
			SPAN_MID: return $signed($urandom_range(1 << 21)) - 32'sd1048576;
			default: return $urandom;
		endcase
	endfunction

	// Radii are often cut down to a random width so that they land near the
	// distances that narrow and mid-range vectors produce.
	function automatic logic [bed_pkg::RADIUS_W-1:0] pick_radius();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return '0;
			1: return RADIUS_MAX;
			2: return raw[bed_pkg::RADIUS_W-1:0];
			default: return raw[bed_pkg::RADIUS_W-1:0] &
				((48'd1 << $urandom_range(40, 1)) - 48'd1);
		endcase
	endfunction

	task automatic add_beat(input logic signed [bed_pkg::VALUE_W-1:0] fv,
			input logic signed [bed_pkg::VALUE_W-1:0] sv,
			input logic fp, input logic sp, input logic last,
			input logic [bed_pkg::RADIUS_W-1:0] fr,
			input logic [bed_pkg::RADIUS_W-1:0] sr, input bit hold);
		pair_beat_t beat;
		beat.first_value    = fv;
		beat.second_value   = sv;
		beat.first_present  = fp;
		beat.second_present = sp;
		beat.last_pair      = last;
		beat.first_radius   = fr;
		beat.second_radius  = sr;
		beat.hold_for_drain = hold;
		pending_beats.push_back(beat);
	endtask

	// One random vector pair. Well-formed pairs have prefix-shaped presence,
	// with the longer vector setting the number of beats; broken ones draw
	// presence at random per position, holes included. Twins copy the first
	// vector into the second, with the odd element spoilt.
	task automatic add_random_vectors(input bit hold);
		int unsigned len_a;
		int unsigned len_b;
		int unsigned swap_len;
		int unsigned steps;
		int unsigned roll;
		bit          twin;
		bit          broken;
		value_span_t span;
		logic signed [bed_pkg::VALUE_W-1:0] fv;
		logic signed [bed_pkg::VALUE_W-1:0] sv;
		logic fp;
		logic sp;
		broken = $urandom_range(99) < 15;
		twin   = $urandom_range(3) == 0;
		span   = value_span_t'($urandom_range(3));
		roll   = $urandom_range(99);
		len_a  = (roll < 5) ? 0 : (roll < 90) ? $urandom_range(8, 1) : $urandom_range(24, 9);
		len_b  = twin ? len_a : $urandom_range(len_a);
		if ($urandom_range(1)) begin
			swap_len = len_a;
			len_a    = len_b;
			len_b    = swap_len;
		end
		// Two empty vectors still take one beat, with nothing present.
		steps = (len_a > len_b) ? len_a : len_b;
		if (steps == 0)
			steps = 1;
		for (int unsigned i = 0; i < steps; i++) begin
			fp = broken ? 1'($urandom_range(1)) : (i < len_a);
			sp = broken ? 1'($urandom_range(1)) : (i < len_b);
			fv = pick_value(span);
			sv = (twin && $urandom_range(19) != 0) ? fv : pick_value(span);
			add_beat(fv, sv, fp, sp, i == steps - 1, pick_radius(), pick_radius(),
				hold && i == 0);
		end
	endtask

	// Both sides pause at random, except while the run is in its calm stretch.
	function automatic bit take_pause();
		if (beats_taken >= CALM_FROM && beats_taken < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < PAUSE_PERCENT;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic compare_result(input ball_result_t got, input ball_result_t want);
		string diff;
		diff = "";
		if (got.ball_distance !== want.ball_distance)
			diff = {diff, $sformatf(" ball_distance %h/%h", got.ball_distance,
				want.ball_distance)};
		if (got.outer_gap !== want.outer_gap)
			diff = {diff, $sformatf(" outer_gap %h/%h", got.outer_gap, want.outer_gap)};
		if (got.balls_overlap !== want.balls_overlap)
			diff = {diff, $sformatf(" balls_overlap %b/%b", got.balls_overlap,
				want.balls_overlap)};
		if (got.first_contains_second !== want.first_contains_second)
			diff = {diff, $sformatf(" first_contains_second %b/%b",
				got.first_contains_second, want.first_contains_second)};
		if (got.second_contains_first !== want.second_contains_first)
			diff = {diff, $sformatf(" second_contains_first %b/%b",
				got.second_contains_first, want.second_contains_first)};
		if (got.vectors_equal !== want.vectors_equal)
			diff = {diff, $sformatf(" vectors_equal %b/%b", got.vectors_equal,
				want.vectors_equal)};
		if (got.sum_saturated !== want.sum_saturated)
			diff = {diff, $sformatf(" sum_saturated %b/%b", got.sum_saturated,
				want.sum_saturated)};
		if (diff != "")
			report_mismatch($sformatf("result %0d (got/want):%s", results_seen, diff));
	endtask

	// ------------------------------------------------------------------------
	// Pair driver
	// ------------------------------------------------------------------------
	// A beat on the wire is held, payload and all, until it is taken. Only
	// once the slot is free does the driver choose between the next queued
	// beat and a pause, so valid never depends on stall. A beat marked to
	// hold for drain is kept back until no result is outstanding.
	always @(posedge clk) begin
		if (!arst_n) begin
			pair_valid <= 1'b0;
		end else begin
			if (pair_valid && !pair_stall) begin
				accumulate_pair(beat_on_wire);
				beats_taken++;
			end
			if (!pair_valid || !pair_stall) begin
				if (pending_beats.size() != 0 && !take_pause() &&
						!(pending_beats[0].hold_for_drain && awaited_results.size() != 0)) begin
					beat_on_wire = pending_beats.pop_front();
					first_value    <= beat_on_wire.first_value;
					second_value   <= beat_on_wire.second_value;
					first_present  <= beat_on_wire.first_present;
					second_present <= beat_on_wire.second_present;
					last_pair      <= beat_on_wire.last_pair;
					first_radius   <= beat_on_wire.first_radius;
					second_radius  <= beat_on_wire.second_radius;
					pair_valid     <= 1'b1;
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------
	// Outputs are read at the edge, before this edge's updates land, so the
	// values compared are the ones that went with the accepted beat.
	always @(posedge clk) begin : result_monitor
		ball_result_t observed;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				observed.ball_distance         = ball_distance;
				observed.outer_gap             = outer_gap;
				observed.balls_overlap         = balls_overlap;
				observed.first_contains_second = first_contains_second;
				observed.second_contains_first = second_contains_first;
				observed.vectors_equal         = vectors_equal;
				observed.sum_saturated         = sum_saturated;
				if (awaited_results.size() == 0)
					report_mismatch("result beat with no result outstanding");
				else
					compare_result(observed, awaited_results.pop_front());
				results_seen++;
			end
			result_stall <= take_pause();
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	// Any beat on either channel counts as progress. The longest quiet spell
	// in a healthy run is the drain pause.
	always @(posedge clk) begin
		if (!arst_n || (pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned total_beats;

		// Two empty vectors: nothing present, so distance zero and equal,
		// whatever the value fields carry.
		add_beat(VALUE_MAX, VALUE_MIN, 1'b0, 1'b0, 1'b1, '0, '0, 1'b0);
		// Widest single difference, with both radii at full scale so that
		// their sum runs past 48 bits.
		add_beat(VALUE_MAX, VALUE_MIN, 1'b1, 1'b1, 1'b1, RADIUS_MAX, RADIUS_MAX, 1'b0);
		// Two widest differences overflow the sum; the distance comes from
		// the clamped value.
		add_beat(VALUE_MAX, VALUE_MIN, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(VALUE_MIN, VALUE_MAX, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(32'sd0, 32'sd0, 1'b1, 1'b1, 1'b1, RADIUS_MAX, '0, 1'b0);
		// Identical vectors built from the extreme values.
		add_beat(VALUE_MIN, VALUE_MIN, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(-32'sd1, -32'sd1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(VALUE_MAX, VALUE_MAX, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
		// Lengths differ while every square is zero: distance zero, not equal.
		add_beat(32'sd7, 32'sd7, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(32'sd0, 32'sd55, 1'b1, 1'b0, 1'b1, '0, '0, 1'b0);
		// A pair with neither side present in the middle leaves equality.
		add_beat(32'sd5, 32'sd5, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
		add_beat(VALUE_MAX, VALUE_MIN, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
		add_beat(-32'sd2, -32'sd2, 1'b1, 1'b1, 1'b1, 48'd9, 48'd9, 1'b0);
		// The first ball contains the second, then the other way round.
		add_beat(32'sd0, 32'sd3, 1'b1, 1'b1, 1'b1, 48'd1000000, 48'd1000, 1'b0);
		add_beat(32'sd10, 32'sd0, 1'b1, 1'b1, 1'b1, 48'd5, 48'd2000000, 1'b0);
		// Balls well apart, so the outer gap is positive.
		add_beat(32'sd1000, -32'sd1000, 1'b1, 1'b1, 1'b1, 48'd1000, 48'd2000, 1'b0);
		// Distance exactly equal to the radius sum: no overlap, no gap.
		add_beat(32'sd0, 32'sd1, 1'b1, 1'b1, 1'b1, 48'd65536, '0, 1'b0);

		// The first random vector pair waits for the directed results to
		// drain; later ones now and then do the same.
		add_random_vectors(1'b1);
		while (pending_beats.size() < TARGET_BEATS)
			add_random_vectors($urandom_range(49) == 0);
		total_beats = pending_beats.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled away from the active edge so the queues are settled.
		do
			@(negedge clk);
		while (beats_taken < total_beats || awaited_results.size() != 0);
		// Room for any stray result that the block might still put out.
		repeat (4 * ROOT_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
